// ===== hw/rtl/rzm_pkg.sv =====
// Shared types and constants for the zone map fill and lookup block.
// Used by the front end, the command queue, the back end and the top level.
package rzm_pkg;

  localparam int ZONE_W  = 8;
  localparam int RUN_W   = 17;
  localparam int COORD_W = 32;
  localparam int POS_W   = 17;

  // Cell index width of the largest supported map (1024 by 1024).
  localparam int CELL_AW = 20;

  // Coordinate to cell: floor((36 * v + CELL_OFFSET) / CELL_DIVISOR) for a Q23.8 value v.
  localparam int NUM_W        = 39;
  localparam int CELL_OFFSET  = 157286400;
  localparam int CELL_DIVISOR = 1228800;

  // The divisor is 2^14 * 75; the odd factor is removed by a reciprocal multiply.
  localparam int DIV_SHIFT   = 14;
  localparam int DIV_ODD     = 75;
  localparam int QUOT_W      = 17;
  localparam int RECIP_SHIFT = 24;
  localparam int RECIP_W     = 18;
  localparam int RECIP       = ((1 << RECIP_SHIFT) + DIV_ODD - 1) / DIV_ODD;
  localparam int PROD_W      = QUOT_W + RECIP_W;

  typedef enum logic [1:0] {
    CMD_LOAD,
    CMD_NO_PLAYER,
    CMD_OUT_OF_RANGE,
    CMD_LOOKUP
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t           kind;
    logic                map_start;
    logic [ZONE_W-1:0]   zone_id;
    logic [RUN_W-1:0]    run_length;
    logic [CELL_AW-1:0]  q_cell;
    logic [CELL_AW-1:0]  p_cell;
  } cmd_t;

endpackage

// ===== hw/rtl/rzm_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with registered data.
// Self-contained; no package needed.
module rzm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rd_data_r <= mem_r[raddr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== hw/rtl/rzm_queue.sv =====
// Two-entry command queue between the front end and the back end.
// Depends on rzm_pkg for the command type.
module rzm_queue import rzm_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output cmd_t head,
  output logic empty
);

  localparam int DEPTH = 2;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  cmd_t             slot_r [DEPTH];
  logic [IDX_W-1:0] wr_r;
  logic [IDX_W-1:0] rd_r;
  logic [CNT_W-1:0] count_r;

  assign full  = (count_r == CNT_W'(DEPTH));
  assign empty = (count_r == '0);
  assign head  = slot_r[rd_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r    <= '0;
      rd_r    <= '0;
      count_r <= '0;
    end else begin
      if (push) begin
        wr_r <= wr_r + IDX_W'(1);
      end
      if (pop) begin
        rd_r <= rd_r + IDX_W'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + CNT_W'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
    if (push) begin
      slot_r[wr_r] <= push_cmd;
    end
  end

`ifndef SYNTHESIS
  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full) else $error("command pushed into a full queue");

  a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty) else $error("command popped from an empty queue");
`endif

endmodule

// ===== hw/rtl/rzm_front.sv =====
// Front end: accepts items, classifies them and turns query coordinates into cell indices.
// Depends on rzm_pkg; feeds rzm_queue.
module rzm_front import rzm_pkg::*; #(
  parameter int MAP_SIDE = 256
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic                      mode,
  input  logic                      map_start,
  input  logic [ZONE_W-1:0]         zone_id,
  input  logic [RUN_W-1:0]          run_length,
  input  logic signed [COORD_W-1:0] query_x,
  input  logic signed [COORD_W-1:0] query_y,
  input  logic                      player_present,
  input  logic signed [COORD_W-1:0] player_x,
  input  logic signed [COORD_W-1:0] player_y,
  output logic                      push,
  output cmd_t                      push_cmd,
  input  logic                      full
);

  localparam int SIDE_W = $clog2(MAP_SIDE);
  localparam int ADDR_W = $clog2(MAP_SIDE * MAP_SIDE);
  localparam int NCOORD = 4;
  localparam int QX = 0;
  localparam int QY = 1;
  localparam int PX = 2;
  localparam int PY = 3;
  localparam logic [NUM_W-1:0] NUM_LIMIT = NUM_W'(MAP_SIDE * CELL_DIVISOR);

  typedef enum logic [2:0] {F_IDLE, F_NUM, F_MUL, F_IDX, F_PUSH} fstate_t;

  fstate_t             state_r, state_nxt;
  cmd_t                cmd_r, cmd_nxt;
  logic [COORD_W-1:0]  coord_r [NCOORD];
  logic [COORD_W-1:0]  coord_nxt [NCOORD];
  logic [NUM_W-1:0]    ext_w [NCOORD];
  logic [NUM_W-1:0]    num_r [NCOORD];
  logic [NUM_W-1:0]    num_nxt [NCOORD];
  logic                inr_r [NCOORD];
  logic                inr_nxt [NCOORD];
  logic [PROD_W-1:0]   prod_r [NCOORD];
  logic [PROD_W-1:0]   prod_nxt [NCOORD];
  logic [SIDE_W-1:0]   cell_w [NCOORD];
  logic [ADDR_W-1:0]   q_idx, p_idx;
  logic                accept;

  assign accept = start && (state_r == F_IDLE);
  assign busy   = (state_r != F_IDLE);
  assign push   = (state_r == F_PUSH) && !full;
  assign push_cmd = cmd_r;

  // The arithmetic stages run freely on the captured coordinates; the state
  // machine only decides when each stage's register is looked at.
  always_comb begin
    for (int i = 0; i < NCOORD; i++) begin
      ext_w[i]   = {{(NUM_W - COORD_W){coord_r[i][COORD_W-1]}}, coord_r[i]};
      num_nxt[i] = (ext_w[i] << 5) + (ext_w[i] << 2) + NUM_W'(CELL_OFFSET);
      inr_nxt[i] = !num_r[i][NUM_W-1] && (num_r[i] < NUM_LIMIT);
      prod_nxt[i] = PROD_W'(num_r[i][DIV_SHIFT +: QUOT_W]) * PROD_W'(RECIP);
      cell_w[i]  = prod_r[i][RECIP_SHIFT +: SIDE_W];
    end
    q_idx = ADDR_W'(cell_w[QX]) * ADDR_W'(MAP_SIDE) + ADDR_W'(cell_w[QY]);
    p_idx = ADDR_W'(cell_w[PX]) * ADDR_W'(MAP_SIDE) + ADDR_W'(cell_w[PY]);
  end

  always_comb begin
    state_nxt = state_r;
    cmd_nxt   = cmd_r;
    for (int i = 0; i < NCOORD; i++) begin
      coord_nxt[i] = coord_r[i];
    end
    unique case (state_r)
      F_IDLE: begin
        if (accept) begin
          coord_nxt[QX] = query_x;
          coord_nxt[QY] = query_y;
          coord_nxt[PX] = player_x;
          coord_nxt[PY] = player_y;
          cmd_nxt.map_start  = map_start;
          cmd_nxt.zone_id    = zone_id;
          cmd_nxt.run_length = run_length;
          cmd_nxt.q_cell     = '0;
          cmd_nxt.p_cell     = '0;
          if (!mode) begin
            cmd_nxt.kind = CMD_LOAD;
            state_nxt    = F_PUSH;
          end else if (!player_present) begin
            cmd_nxt.kind = CMD_NO_PLAYER;
            state_nxt    = F_PUSH;
          end else begin
            cmd_nxt.kind = CMD_LOOKUP;
            state_nxt    = F_NUM;
          end
        end
      end
      F_NUM: begin
        state_nxt = F_MUL;
      end
      F_MUL: begin
        state_nxt = F_IDX;
      end
      F_IDX: begin
        cmd_nxt.kind   = (inr_r[QX] && inr_r[QY] && inr_r[PX] && inr_r[PY]) ?
                         CMD_LOOKUP : CMD_OUT_OF_RANGE;
        cmd_nxt.q_cell = CELL_AW'(q_idx);
        cmd_nxt.p_cell = CELL_AW'(p_idx);
        state_nxt      = F_PUSH;
      end
      F_PUSH: begin
        if (!full) begin
          state_nxt = F_IDLE;
        end
      end
      default: begin
        state_nxt = F_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    cmd_r <= cmd_nxt;
    for (int i = 0; i < NCOORD; i++) begin
      coord_r[i] <= coord_nxt[i];
      num_r[i]   <= num_nxt[i];
      inr_r[i]   <= inr_nxt[i];
      prod_r[i]  <= prod_nxt[i];
    end
  end

endmodule

// ===== hw/rtl/rzm_back.sv =====
// Back end: executes queued commands against the zone map RAM and drives the result.
// Depends on rzm_pkg and rzm_ram; takes commands from rzm_queue.
module rzm_back import rzm_pkg::*; #(
  parameter int MAP_SIDE = 256
) (
  input  logic             clk,
  input  logic             rst_n,
  input  cmd_t             head,
  input  logic             empty,
  output logic             pop,
  output logic             out_valid,
  output logic             out_in_zone,
  output logic             out_out_of_range,
  output logic [POS_W-1:0] out_fill_position,
  output logic             out_fill_overflow,
  output logic             out_map_complete
);

  localparam int CELLS  = MAP_SIDE * MAP_SIDE;
  localparam int ADDR_W = $clog2(CELLS);
  localparam int PTR_W  = ADDR_W + 1;
  localparam int CMP_W  = (PTR_W > RUN_W) ? PTR_W : RUN_W;
  localparam logic [PTR_W-1:0] CELLS_P = PTR_W'(CELLS);

  typedef enum logic [1:0] {B_IDLE, B_FILL, B_RD1, B_CMP} bstate_t;

  bstate_t            state_r, state_nxt;
  logic [PTR_W-1:0]   ptr_r, ptr_nxt;
  logic [PTR_W-1:0]   hwm_r, hwm_nxt;
  logic [PTR_W-1:0]   rem_r, rem_nxt;
  logic [ZONE_W-1:0]  zone_r, zone_nxt;
  logic               ovf_r, ovf_nxt;
  logic [ADDR_W-1:0]  pcell_r, pcell_nxt;
  logic               qv_r, qv_nxt;
  logic               pv_r, pv_nxt;
  logic [ZONE_W-1:0]  zq_r, zq_nxt;

  logic               out_valid_r;
  logic               out_in_zone_r;
  logic               out_out_of_range_r;
  logic [POS_W-1:0]   out_fill_position_r;
  logic               out_fill_overflow_r;
  logic               out_map_complete_r;

  logic               res_valid, res_in_zone, res_oor, res_ovf;
  logic [PTR_W-1:0]   res_pos;
  logic [CMP_W-1:0]   res_pos_ext;

  logic [PTR_W-1:0]   base, room, run_clip;
  logic [CMP_W-1:0]   run_ext;
  logic               clip;
  logic [ADDR_W-1:0]  q_addr;

  logic               we;
  logic [ADDR_W-1:0]  raddr;
  logic [ZONE_W-1:0]  rd_data;

  rzm_ram #(
    .WIDTH (ZONE_W),
    .DEPTH (CELLS)
  ) u_map (
    .clk     (clk),
    .we      (we),
    .waddr   (ptr_r[ADDR_W-1:0]),
    .wdata   (zone_r),
    .raddr   (raddr),
    .rd_data (rd_data)
  );

  // Load preparation: restart point, room left and the run cut to fit.
  assign base     = head.map_start ? '0 : ptr_r;
  assign room     = CELLS_P - base;
  assign run_ext  = CMP_W'(head.run_length);
  assign clip     = run_ext > CMP_W'(room);
  assign run_clip = clip ? room : run_ext[PTR_W-1:0];
  assign q_addr   = head.q_cell[ADDR_W-1:0];
  assign raddr    = (state_r == B_RD1) ? pcell_r : q_addr;

  // Writes always run on from the fill pointer, which never passes the
  // high-water mark, so the written cells form a prefix of the map. A cell at
  // or beyond the mark reads as zero, as a lookup puts zero in place of its data.
  always_comb begin
    state_nxt   = state_r;
    ptr_nxt     = ptr_r;
    hwm_nxt     = hwm_r;
    rem_nxt     = rem_r;
    zone_nxt    = zone_r;
    ovf_nxt     = ovf_r;
    pcell_nxt   = pcell_r;
    qv_nxt      = qv_r;
    pv_nxt      = pv_r;
    zq_nxt      = zq_r;
    pop         = 1'b0;
    we          = 1'b0;
    res_valid   = 1'b0;
    res_in_zone = 1'b0;
    res_oor     = 1'b0;
    res_ovf     = 1'b0;
    res_pos     = ptr_r;
    unique case (state_r)
      B_IDLE: begin
        if (!empty) begin
          pop = 1'b1;
          unique case (head.kind)
            CMD_LOAD: begin
              ptr_nxt = base;
              if (run_clip == '0) begin
                res_valid = 1'b1;
                res_pos   = base;
                res_ovf   = clip;
              end else begin
                rem_nxt   = run_clip;
                zone_nxt  = head.zone_id;
                ovf_nxt   = clip;
                state_nxt = B_FILL;
              end
            end
            CMD_NO_PLAYER: begin
              res_valid   = 1'b1;
              res_in_zone = 1'b1;
            end
            CMD_OUT_OF_RANGE: begin
              res_valid = 1'b1;
              res_oor   = 1'b1;
            end
            CMD_LOOKUP: begin
              pcell_nxt = head.p_cell[ADDR_W-1:0];
              qv_nxt    = PTR_W'(q_addr) < hwm_r;
              pv_nxt    = PTR_W'(head.p_cell[ADDR_W-1:0]) < hwm_r;
              state_nxt = B_RD1;
            end
          endcase
        end
      end
      B_FILL: begin
        we      = 1'b1;
        ptr_nxt = ptr_r + PTR_W'(1);
        rem_nxt = rem_r - PTR_W'(1);
        if (ptr_r == hwm_r) begin
          hwm_nxt = hwm_r + PTR_W'(1);
        end
        if (rem_r == PTR_W'(1)) begin
          res_valid = 1'b1;
          res_pos   = ptr_r + PTR_W'(1);
          res_ovf   = ovf_r;
          state_nxt = B_IDLE;
        end
      end
      B_RD1: begin
        zq_nxt    = qv_r ? rd_data : '0;
        state_nxt = B_CMP;
      end
      B_CMP: begin
        res_valid   = 1'b1;
        res_in_zone = (zq_r == (pv_r ? rd_data : '0));
        state_nxt   = B_IDLE;
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase
  end

  assign res_pos_ext = CMP_W'(res_pos);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      ptr_r       <= '0;
      hwm_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ptr_r       <= ptr_nxt;
      hwm_r       <= hwm_nxt;
      out_valid_r <= res_valid;
    end
    rem_r               <= rem_nxt;
    zone_r              <= zone_nxt;
    ovf_r               <= ovf_nxt;
    pcell_r             <= pcell_nxt;
    qv_r                <= qv_nxt;
    pv_r                <= pv_nxt;
    zq_r                <= zq_nxt;
    out_in_zone_r       <= res_in_zone;
    out_out_of_range_r  <= res_oor;
    out_fill_position_r <= res_pos_ext[POS_W-1:0];
    out_fill_overflow_r <= res_ovf;
    out_map_complete_r  <= (res_pos == CELLS_P);
  end

  assign out_valid         = out_valid_r;
  assign out_in_zone       = out_in_zone_r;
  assign out_out_of_range  = out_out_of_range_r;
  assign out_fill_position = out_fill_position_r;
  assign out_fill_overflow = out_fill_overflow_r;
  assign out_map_complete  = out_map_complete_r;

`ifndef SYNTHESIS
  a_ptr_within_mark: assert property (@(posedge clk) disable iff (!rst_n)
    ptr_r <= hwm_r) else $error("fill pointer has passed the high-water mark");

  a_mark_within_map: assert property (@(posedge clk) disable iff (!rst_n)
    hwm_r <= CELLS_P) else $error("high-water mark beyond the map end");

  a_fill_has_work: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_FILL) |-> (rem_r != '0)) else $error("fill running with no cells left");

  a_result_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_in_zone_r && out_out_of_range_r))
    else $error("result both in zone and out of range");
`endif

endmodule

// ===== hw/rtl/rle_zone_map_fill_and_lookup_top.sv =====
// Top level of the zone map fill and lookup block.
// Depends on rzm_pkg, rzm_front, rzm_queue and rzm_back (which holds rzm_ram).

// An item is taken when start is high and busy is low. Each result appears on
// the out_ ports for exactly one cycle with out_valid high and cannot be held
// off, so the block never waits on its receiver. The front end keeps busy high
// until the command for its item has been pushed into the queue, so it takes
// no new item before it is through with the last. A query's four coordinates
// pass through a three-stage convert pipeline (offset add, range check with a
// reciprocal multiply, cell index). Accepted commands wait in a two-entry queue
// for the back end, which owns the map RAM. A load writes the map one cell a
// cycle over its (clipped) run. A load that writes nothing, a query without a
// player or an out-of-range query is answered from the idle state without a
// map access. A map query reads its two cells in turn from the one read port.
// During a long load the queue fills and busy stays high until it drains. No
// clearing pass follows reset: a high-water mark over the written prefix of the
// map makes unwritten cells read as zone zero.
module rle_zone_map_fill_and_lookup_top import rzm_pkg::*; #(
  parameter int MAP_SIDE = 256
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic                      in_mode,
  input  logic                      in_map_start,
  input  logic [ZONE_W-1:0]         in_zone_id,
  input  logic [RUN_W-1:0]          in_run_length,
  input  logic signed [COORD_W-1:0] in_query_x,
  input  logic signed [COORD_W-1:0] in_query_y,
  input  logic                      in_player_present,
  input  logic signed [COORD_W-1:0] in_player_x,
  input  logic signed [COORD_W-1:0] in_player_y,
  output logic                      out_valid,
  output logic                      out_in_zone,
  output logic                      out_out_of_range,
  output logic [POS_W-1:0]          out_fill_position,
  output logic                      out_fill_overflow,
  output logic                      out_map_complete
);

  logic push, full, pop, empty;
  cmd_t push_cmd, head;

  rzm_front #(
    .MAP_SIDE (MAP_SIDE)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .mode           (in_mode),
    .map_start      (in_map_start),
    .zone_id        (in_zone_id),
    .run_length     (in_run_length),
    .query_x        (in_query_x),
    .query_y        (in_query_y),
    .player_present (in_player_present),
    .player_x       (in_player_x),
    .player_y       (in_player_y),
    .push           (push),
    .push_cmd       (push_cmd),
    .full           (full)
  );

  rzm_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (full),
    .pop      (pop),
    .head     (head),
    .empty    (empty)
  );

  rzm_back #(
    .MAP_SIDE (MAP_SIDE)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .head              (head),
    .empty             (empty),
    .pop               (pop),
    .out_valid         (out_valid),
    .out_in_zone       (out_in_zone),
    .out_out_of_range  (out_out_of_range),
    .out_fill_position (out_fill_position),
    .out_fill_overflow (out_fill_overflow),
    .out_map_complete  (out_map_complete)
  );

endmodule

// ===== bench/tb_top.sv =====
// Self-checking bench for the zone map fill and lookup block: directed and random
// run loads and zone queries, checked against a behavioural model of the map.
// Depends on rzm_pkg and the rle_zone_map_fill_and_lookup_top RTL.
`timescale 1ns / 100ps

module tb_top import rzm_pkg::*; ();

  localparam int          MAP_SIDE       = 256;
  localparam int unsigned MAP_CELLS      = MAP_SIDE * MAP_SIDE;
  localparam longint      GRID_OFFSET    = 64'sd157286400;
  localparam longint      GRID_DIVISOR   = 64'sd1228800;
  // Extreme Q23.8 values: EDGE_IN still lands inside the grid, EDGE_OUT just outside.
  localparam int          EDGE_IN        = 4369066;
  localparam int          EDGE_OUT       = 4369067;
  localparam int          RANDOM_ITEMS   = 1030;
  localparam int          WATCHDOG_LIMIT = 200000;
  localparam int          REPORT_LIMIT   = 10;

  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  typedef struct packed {
    logic                      mode;
    logic                      map_start;
    logic [ZONE_W-1:0]         zone_id;
    logic [RUN_W-1:0]          run_length;
    logic signed [COORD_W-1:0] query_x;
    logic signed [COORD_W-1:0] query_y;
    logic                      player_present;
    logic signed [COORD_W-1:0] player_x;
    logic signed [COORD_W-1:0] player_y;
  } zone_cmd_t;

  typedef struct packed {
    logic             in_zone;
    logic             out_of_range;
    logic [POS_W-1:0] fill_position;
    logic             fill_overflow;
    logic             map_complete;
  } zone_answer_t;

  logic                      clk;
  logic                      rst_n;
  logic                      start;
  logic                      busy;
  logic                      in_mode;
  logic                      in_map_start;
  logic [ZONE_W-1:0]         in_zone_id;
  logic [RUN_W-1:0]          in_run_length;
  logic signed [COORD_W-1:0] in_query_x;
  logic signed [COORD_W-1:0] in_query_y;
  logic                      in_player_present;
  logic signed [COORD_W-1:0] in_player_x;
  logic signed [COORD_W-1:0] in_player_y;
  logic                      out_valid;
  logic                      out_in_zone;
  logic                      out_out_of_range;
  logic [POS_W-1:0]          out_fill_position;
  logic                      out_fill_overflow;
  logic                      out_map_complete;

  // Behavioural copy of the map and its fill pointer.
  logic [ZONE_W-1:0] zone_model [MAP_CELLS];
  int unsigned       fill_ptr;
  int unsigned       high_water;

  zone_answer_t pending_answers[$];
  int           mismatch_count;
  int           burst_left;

  rle_zone_map_fill_and_lookup_top #(.MAP_SIDE(MAP_SIDE)) dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_mode           (in_mode),
    .in_map_start      (in_map_start),
    .in_zone_id        (in_zone_id),
    .in_run_length     (in_run_length),
    .in_query_x        (in_query_x),
    .in_query_y        (in_query_y),
    .in_player_present (in_player_present),
    .in_player_x       (in_player_x),
    .in_player_y       (in_player_y),
    .out_valid         (out_valid),
    .out_in_zone       (out_in_zone),
    .out_out_of_range  (out_out_of_range),
    .out_fill_position (out_fill_position),
    .out_fill_overflow (out_fill_overflow),
    .out_map_complete  (out_map_complete)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Floor of (36 * v + offset) / divisor; -1 when the cell is off the grid.
  function automatic int grid_cell(logic signed [COORD_W-1:0] v);
    longint num;
    longint q;
    num = 36 * longint'(v) + GRID_OFFSET;
    if (num >= 0) begin
      q = num / GRID_DIVISOR;
    end else begin
      q = -((-num + GRID_DIVISOR - 1) / GRID_DIVISOR);
    end
    if (q < 0 || q >= MAP_SIDE) return -1;
    return int'(q);
  endfunction

  // A random coordinate that falls in the given row or column of the grid.
  function automatic logic signed [COORD_W-1:0] coord_in_cell(int cell_idx);
    longint n;
    longint lo;
    n = longint'(cell_idx) * GRID_DIVISOR - GRID_OFFSET;
    if (n >= 0) begin
      lo = (n + 35) / 36;
    end else begin
      lo = -((-n) / 36);
    end
    return COORD_W'(lo + longint'($urandom_range(0, 34132)));
  endfunction

  function automatic logic signed [COORD_W-1:0] coord_off_grid();
    if ($urandom_range(0, 1) == 0) return EDGE_OUT + $urandom_range(0, 1000000);
    return -EDGE_OUT - $urandom_range(0, 1000000);
  endfunction

  task automatic apply_zone_cmd(input zone_cmd_t c, output zone_answer_t r);
    int unsigned run;
    int unsigned room;
    int qx, qy, px, py;
    r = '0;
    if (c.mode == MODE_LOAD) begin
      run = c.run_length;
      if (c.map_start) fill_ptr = 0;
      room = MAP_CELLS - fill_ptr;
      if (run > room) begin
        run = room;
        r.fill_overflow = 1'b1;
      end
      for (int unsigned i = 0; i < run; i++) zone_model[fill_ptr + i] = c.zone_id;
      fill_ptr += run;
      if (fill_ptr > high_water) high_water = fill_ptr;
    end else if (!c.player_present) begin
      r.in_zone = 1'b1;
    end else begin
      qx = grid_cell(c.query_x);
      qy = grid_cell(c.query_y);
      px = grid_cell(c.player_x);
      py = grid_cell(c.player_y);
      if (qx < 0 || qy < 0 || px < 0 || py < 0) begin
        r.out_of_range = 1'b1;
      end else begin
        r.in_zone = (zone_model[qx * MAP_SIDE + qy] == zone_model[px * MAP_SIDE + py]);
      end
    end
    r.fill_position = fill_ptr[POS_W-1:0];
    r.map_complete  = (fill_ptr == MAP_CELLS);
  endtask

  // Drives one item at the falling edge, with bursts and random gaps between them.
  task automatic send_item(input zone_cmd_t c);
    zone_answer_t r;
    int gap;
    if (burst_left == 0) begin
      if ($urandom_range(0, 4) == 0) begin
        gap        = 0;
        burst_left = $urandom_range(24, 64);
      end else begin
        gap        = $urandom_range(1, 8);
        burst_left = $urandom_range(1, 10);
      end
      if (gap > 0) begin
        @(negedge clk);
        start <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    @(negedge clk);
    start             <= 1'b1;
    in_mode           <= c.mode;
    in_map_start      <= c.map_start;
    in_zone_id        <= c.zone_id;
    in_run_length     <= c.run_length;
    in_query_x        <= c.query_x;
    in_query_y        <= c.query_y;
    in_player_present <= c.player_present;
    in_player_x       <= c.player_x;
    in_player_y       <= c.player_y;
    do @(posedge clk); while (busy);
    apply_zone_cmd(c, r);
    pending_answers.push_back(r);
    burst_left--;
  endtask

  // Every field random; the fields that the operation ignores keep these values.
  function automatic zone_cmd_t random_cmd();
    zone_cmd_t c;
    c.mode           = 1'($urandom_range(0, 1));
    c.map_start      = 1'($urandom_range(0, 1));
    c.zone_id        = ZONE_W'($urandom_range(0, 255));
    c.run_length     = RUN_W'($urandom_range(0, 65536));
    c.query_x        = $urandom();
    c.query_y        = $urandom();
    c.player_present = 1'($urandom_range(0, 1));
    c.player_x       = $urandom();
    c.player_y       = $urandom();
    return c;
  endfunction

  task automatic load_run(input logic restart, input logic [ZONE_W-1:0] id,
                          input logic [RUN_W-1:0] len);
    zone_cmd_t c;
    c            = random_cmd();
    c.mode       = MODE_LOAD;
    c.map_start  = restart;
    c.zone_id    = id;
    c.run_length = len;
    send_item(c);
  endtask

  task automatic ask_zone(input logic present,
                          input logic signed [COORD_W-1:0] qx, qy, px, py);
    zone_cmd_t c;
    c                = random_cmd();
    c.mode           = MODE_QUERY;
    c.player_present = present;
    c.query_x        = qx;
    c.query_y        = qy;
    c.player_x       = px;
    c.player_y       = py;
    send_item(c);
  endtask

  task automatic test_after_reset();
    ask_zone(1'b0, coord_in_cell(3), coord_in_cell(7), coord_in_cell(0), coord_in_cell(0));
    ask_zone(1'b1, coord_in_cell(0), coord_in_cell(0), coord_in_cell(200), coord_in_cell(9));
  endtask

  task automatic test_small_loads_and_lookups();
    load_run(1'b1, 8'hFF, 17'd0);
    load_run(1'b1, 8'hA5, 17'd1);
    load_run(1'b0, 8'h5A, 17'd255);
    ask_zone(1'b1, coord_in_cell(0), coord_in_cell(0), coord_in_cell(0), coord_in_cell(1));
    ask_zone(1'b1, coord_in_cell(0), coord_in_cell(1), coord_in_cell(0), coord_in_cell(255));
    // Row one has never been written and still reads as zone zero.
    ask_zone(1'b1, coord_in_cell(1), coord_in_cell(0), coord_in_cell(0), coord_in_cell(0));
  endtask

  task automatic test_grid_edges();
    ask_zone(1'b1, -EDGE_IN, -EDGE_IN, -EDGE_IN, EDGE_IN);
    ask_zone(1'b1, -EDGE_IN, -EDGE_IN, -EDGE_OUT, -EDGE_IN);
    ask_zone(1'b1, EDGE_OUT, EDGE_IN, EDGE_IN, EDGE_IN);
    ask_zone(1'b1, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF);
    // Without a player the coordinates do not matter, even off the grid.
    ask_zone(1'b0, 32'sh7FFF_FFFF, 32'sh8000_0000, -EDGE_OUT, EDGE_OUT);
  endtask

  task automatic test_full_map();
    load_run(1'b1, 8'h3C, 17'h10000);
    load_run(1'b0, 8'h77, 17'd0);
    load_run(1'b0, 8'h77, 17'd5);
    ask_zone(1'b1, EDGE_IN, EDGE_IN, -EDGE_IN, -EDGE_IN);
    load_run(1'b1, 8'h01, 17'd65535);
    load_run(1'b0, 8'h02, 17'd3);
    ask_zone(1'b1, EDGE_IN, EDGE_IN, coord_in_cell(255), coord_in_cell(254));
    load_run(1'b0, 8'h03, 17'h10000);
    load_run(1'b1, 8'h00, 17'd16);
  endtask

  task automatic test_random_traffic();
    zone_cmd_t c;
    int sel, span, qi, pi;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      c = random_cmd();
      if ($urandom_range(0, 99) < 55) begin
        c.mode      = MODE_LOAD;
        c.map_start = ($urandom_range(0, 24) == 0);
        sel         = $urandom_range(0, 199);
        if (sel == 0) begin
          c.run_length = RUN_W'($urandom_range(256, 65536));
        end else if (sel < 8) begin
          c.run_length = '0;
        end else if (sel < 20) begin
          c.run_length = RUN_W'($urandom_range(64, 1023));
        end else begin
          c.run_length = RUN_W'($urandom_range(1, 63));
        end
      end else begin
        c.mode           = MODE_QUERY;
        sel              = $urandom_range(0, 19);
        c.player_present = (sel != 0);
        if (sel > 1) begin
          // Aim at the written part of the map so that answers vary.
          span = (high_water > 511) ? high_water : 511;
          if (span > MAP_CELLS - 1) span = MAP_CELLS - 1;
          qi = $urandom_range(0, span);
          case ($urandom_range(0, 3))
            0: pi = qi;
            1: pi = (qi < span) ? qi + 1 : qi;
            2: pi = (qi > 0) ? qi - 1 : 0;
            default: pi = $urandom_range(0, span);
          endcase
          c.query_x  = coord_in_cell(qi / MAP_SIDE);
          c.query_y  = coord_in_cell(qi % MAP_SIDE);
          c.player_x = coord_in_cell(pi / MAP_SIDE);
          c.player_y = coord_in_cell(pi % MAP_SIDE);
          if (sel == 2) begin
            case ($urandom_range(0, 3))
              0: c.query_x  = coord_off_grid();
              1: c.query_y  = coord_off_grid();
              2: c.player_x = coord_off_grid();
              default: c.player_y = coord_off_grid();
            endcase
          end
        end
      end
      send_item(c);
    end
  endtask

  task automatic log_mismatch(input string what, input zone_answer_t want,
                              input zone_answer_t got);
    mismatch_count++;
    if (mismatch_count <= REPORT_LIMIT) begin
      $display("%0t: %s: expected in_zone=%0d oor=%0d pos=%0d ovf=%0d complete=%0d",
               $realtime, what, want.in_zone, want.out_of_range, want.fill_position,
               want.fill_overflow, want.map_complete);
      $display("%0t: %s: actual   in_zone=%0d oor=%0d pos=%0d ovf=%0d complete=%0d",
               $realtime, what, got.in_zone, got.out_of_range, got.fill_position,
               got.fill_overflow, got.map_complete);
    end
  endtask

  always @(posedge clk) begin : check_answers
    zone_answer_t got;
    zone_answer_t want;
    if (rst_n && out_valid) begin
      got.in_zone       = out_in_zone;
      got.out_of_range  = out_out_of_range;
      got.fill_position = out_fill_position;
      got.fill_overflow = out_fill_overflow;
      got.map_complete  = out_map_complete;
      if (pending_answers.size() == 0) begin
        log_mismatch("unexpected result", '0, got);
      end else begin
        want = pending_answers.pop_front();
        if (got !== want) log_mismatch("result mismatch", want, got);
      end
    end
  end

  // Ends the run if nothing is taken in or handed out for too long.
  initial begin : watchdog
    int idle_run;
    idle_run = 0;
    while (idle_run < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (start && !busy) || out_valid) begin
        idle_run = 0;
      end else begin
        idle_run++;
      end
    end
    $display("DONE: errors detected");
    $finish;
  end

  initial begin : run_tests
    rst_n             = 1'b0;
    start             = 1'b0;
    in_mode           = MODE_LOAD;
    in_map_start      = 1'b0;
    in_zone_id        = '0;
    in_run_length     = '0;
    in_query_x        = '0;
    in_query_y        = '0;
    in_player_present = 1'b0;
    in_player_x       = '0;
    in_player_y       = '0;
    mismatch_count    = 0;
    burst_left        = 0;
    fill_ptr          = 0;
    high_water        = 0;
    foreach (zone_model[i]) zone_model[i] = '0;

    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    test_after_reset();
    test_small_loads_and_lookups();
    test_grid_edges();
    test_full_map();
    test_random_traffic();

    @(negedge clk);
    start <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    // Allow time for any stray result to show up.
    repeat (32) @(posedge clk);

    if (mismatch_count == 0 && pending_answers.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
